FILE: src/fccs_pkg.sv
// Shared types and constants for the FAT cluster-chain sector stepper.
// Request/result payload structs, register map, FAT kind codes and end marks.
// No dependencies.
package fccs_pkg;

    // Field widths
    localparam int SECTOR_W   = 31;
    localparam int CLUSTER_W  = 28;
    localparam int SHIFT_W    = 4;
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 9;
    localparam int WORD_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Default log2 of the sector size in bytes
    localparam int SECTOR_SHIFT_DEF = 9;

    // Result codes
    typedef enum logic [1:0] {
        OUT_NEXT = 2'd0,
        OUT_NEED = 2'd1,
        OUT_END  = 2'd2,
        OUT_ERR  = 2'd3
    } t_outcome;

    // FAT kind codes
    localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_FAT_START     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROOTDIR_START = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_START    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_END_CLUSTER   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLUSTER_SHIFT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FAT_KIND      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROOT_CLUSTER  = 3'd6;

    // End-of-chain marks, lowest reserved value per FAT kind
    localparam logic [11:0] EOC_FAT12 = 12'hFF8;
    localparam logic [15:0] EOC_FAT16 = 16'hFFF8;
    localparam logic [27:0] EOC_FAT32 = 28'hFFF_FFF8;

    // First cluster of the data area; also reset value of end_cluster
    localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 28'd2;

    typedef struct packed {
        logic                req_type;
        logic [SECTOR_W-1:0] sector;
        logic [WORD_W-1:0]   fat_word;
    } t_in;

    typedef struct packed {
        t_outcome            outcome;
        logic [SECTOR_W-1:0] next_sector;
        logic [SECTOR_W-1:0] fat_sector;
        logic [BYTE_W-1:0]   fat_byte;
    } t_out;

    typedef struct packed {
        logic [SECTOR_W-1:0]  fat_start;
        logic [SECTOR_W-1:0]  rootdir_start;
        logic [SECTOR_W-1:0]  data_start;
        logic [CLUSTER_W-1:0] end_cluster;
        logic [SHIFT_W-1:0]   cluster_shift;
        logic [KIND_W-1:0]    fat_kind;
        logic [CLUSTER_W-1:0] root_cluster;
    } t_cfg;

endpackage

FILE: src/fccs_cfg.sv
// APB register file for the FAT cluster-chain sector stepper.
// Holds the volume geometry registers and hands them out as one struct.
// Depends on fccs_pkg.
module fccs_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fccs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fccs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fccs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fccs_pkg::t_cfg                    o_cfg
);
    import fccs_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fat_start: '0, rootdir_start: '0, data_start: '0,
                       end_cluster: FIRST_CLUSTER, cluster_shift: '0,
                       fat_kind: KIND_FAT12, root_cluster: '0};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FAT_START:     r_cfg.fat_start     <= pwdata[SECTOR_W-1:0];
                REG_ROOTDIR_START: r_cfg.rootdir_start <= pwdata[SECTOR_W-1:0];
                REG_DATA_START:    r_cfg.data_start    <= pwdata[SECTOR_W-1:0];
                REG_END_CLUSTER:   r_cfg.end_cluster   <= pwdata[CLUSTER_W-1:0];
                REG_CLUSTER_SHIFT: r_cfg.cluster_shift <= pwdata[SHIFT_W-1:0];
                REG_FAT_KIND:      r_cfg.fat_kind      <= pwdata[KIND_W-1:0];
                REG_ROOT_CLUSTER:  r_cfg.root_cluster  <= pwdata[CLUSTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FAT_START:     prdata = APB_DATA_W'(r_cfg.fat_start);
            REG_ROOTDIR_START: prdata = APB_DATA_W'(r_cfg.rootdir_start);
            REG_DATA_START:    prdata = APB_DATA_W'(r_cfg.data_start);
            REG_END_CLUSTER:   prdata = APB_DATA_W'(r_cfg.end_cluster);
            REG_CLUSTER_SHIFT: prdata = APB_DATA_W'(r_cfg.cluster_shift);
            REG_FAT_KIND:      prdata = APB_DATA_W'(r_cfg.fat_kind);
            REG_ROOT_CLUSTER:  prdata = APB_DATA_W'(r_cfg.root_cluster);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: src/fccs_step.sv
// Step logic of the FAT cluster-chain sector stepper: sector queries and
// FAT entry decode, plus the pending-cluster state. Depends on fccs_pkg.
module fccs_step #(
    parameter int SECTOR_SHIFT = fccs_pkg::SECTOR_SHIFT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fccs_pkg::t_cfg i_cfg,
    input  logic           i_fire,
    input  fccs_pkg::t_in  i_item,
    output fccs_pkg::t_out o_result
);
    import fccs_pkg::*;

    // Cluster offset shifted by the largest cluster_shift
    localparam int SH_W  = CLUSTER_W + (1 << SHIFT_W) - 1;
    localparam int OFF_W = CLUSTER_W + 2;

    logic [CLUSTER_W-1:0] r_pending;
    logic                 r_awaiting;

    // Query path
    t_out                 q_res;
    logic                 q_need;
    logic [SECTOR_W:0]    s_inc;
    logic [SECTOR_W-1:0]  rs;
    logic [SECTOR_W-1:0]  cl_mask;
    logic [SECTOR_W:0]    cl_wide;
    logic [CLUSTER_W-1:0] cl;
    logic [OFF_W-1:0]     off;
    logic [SECTOR_W:0]    fsec;

    // Delivery path
    t_out                 d_res;
    logic [11:0]          v12;
    logic [CLUSTER_W-1:0] v;
    logic                 d_end;
    logic                 d_bad_kind;
    logic [CLUSTER_W-1:0] cl_m;
    logic [CLUSTER_W-1:0] cl_rel;
    logic [SH_W-1:0]      cl_sh;
    logic [SECTOR_W:0]    d_sum;

    // Step query: root area, inside a cluster, or end of cluster
    always_comb begin
        q_res   = '0;
        q_res.outcome = OUT_ERR;
        q_need  = 1'b0;
        s_inc   = {1'b0, i_item.sector} + (SECTOR_W+1)'(1);
        rs      = i_item.sector - i_cfg.data_start;
        cl_mask = ~({SECTOR_W{1'b1}} << i_cfg.cluster_shift);
        cl_wide = {1'b0, rs >> i_cfg.cluster_shift} + (SECTOR_W+1)'(FIRST_CLUSTER);
        cl      = cl_wide[CLUSTER_W-1:0];
        case (i_cfg.fat_kind)
            KIND_FAT12: off = {2'b00, cl} + {3'b000, cl[CLUSTER_W-1:1]};
            KIND_FAT16: off = {1'b0, cl, 1'b0};
            default:    off = {cl, 2'b00};
        endcase
        fsec    = {1'b0, i_cfg.fat_start} + (SECTOR_W+1)'(off >> SECTOR_SHIFT);

        if (i_item.sector < i_cfg.data_start) begin
            if (i_item.sector < i_cfg.rootdir_start) begin
                q_res.outcome = OUT_ERR;
            end else if (s_inc < {1'b0, i_cfg.data_start}) begin
                q_res.outcome     = OUT_NEXT;
                q_res.next_sector = s_inc[SECTOR_W-1:0];
            end else begin
                q_res.outcome = OUT_END;
            end
        end else if ((rs & cl_mask) != cl_mask) begin
            if (!s_inc[SECTOR_W]) begin
                q_res.outcome     = OUT_NEXT;
                q_res.next_sector = s_inc[SECTOR_W-1:0];
            end
        end else if (cl_wide >= (SECTOR_W+1)'(i_cfg.end_cluster)) begin
            q_res.outcome = OUT_ERR;
        end else if (i_cfg.fat_kind == KIND_FAT12 || i_cfg.fat_kind == KIND_FAT16 ||
                     i_cfg.fat_kind == KIND_FAT32) begin
            if (!fsec[SECTOR_W]) begin
                q_res.outcome    = OUT_NEED;
                q_res.fat_sector = fsec[SECTOR_W-1:0];
                q_res.fat_byte   = off[BYTE_W-1:0];
                q_need           = 1'b1;
            end
        end
    end

    // FAT entry delivery: decode, end-of-chain check, cluster to sector
    always_comb begin
        d_res       = '0;
        d_res.outcome = OUT_ERR;
        d_end       = 1'b0;
        d_bad_kind  = 1'b0;
        v12 = r_pending[0] ? i_item.fat_word[15:4] : i_item.fat_word[11:0];
        case (i_cfg.fat_kind)
            KIND_FAT12: begin
                v     = CLUSTER_W'(v12);
                d_end = v12 >= EOC_FAT12;
            end
            KIND_FAT16: begin
                v     = CLUSTER_W'(i_item.fat_word[15:0]);
                d_end = i_item.fat_word[15:0] >= EOC_FAT16;
            end
            KIND_FAT32: begin
                v     = i_item.fat_word[CLUSTER_W-1:0];
                d_end = i_item.fat_word[CLUSTER_W-1:0] >= EOC_FAT32;
            end
            default: begin
                v          = '0;
                d_bad_kind = 1'b1;
            end
        endcase
        // cluster 0 means the root directory
        cl_m   = (v == '0) ? i_cfg.root_cluster : v;
        cl_rel = cl_m - FIRST_CLUSTER;
        cl_sh  = SH_W'(cl_rel) << i_cfg.cluster_shift;
        d_sum  = {1'b0, i_cfg.data_start} + {1'b0, cl_sh[SECTOR_W-1:0]};

        if (!r_awaiting || d_bad_kind) begin
            d_res.outcome = OUT_ERR;
        end else if (d_end) begin
            d_res.outcome = OUT_END;
        end else if (cl_m == '0) begin
            d_res.outcome     = OUT_NEXT;
            d_res.next_sector = i_cfg.rootdir_start;
        end else if (cl_m < FIRST_CLUSTER || cl_m >= i_cfg.end_cluster) begin
            d_res.outcome = OUT_ERR;
        end else if ((|cl_sh[SH_W-1:SECTOR_W]) || d_sum[SECTOR_W]) begin
            d_res.outcome = OUT_ERR;
        end else begin
            d_res.outcome     = OUT_NEXT;
            d_res.next_sector = d_sum[SECTOR_W-1:0];
        end
    end

    assign o_result = i_item.req_type ? d_res : q_res;

    // Pending FAT request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_pending  <= '0;
        end else if (i_fire) begin
            if (i_item.req_type) begin
                r_awaiting <= 1'b0;
            end else begin
                r_awaiting <= q_need;
                if (q_need) begin
                    r_pending <= cl;
                end
            end
        end
    end

endmodule

FILE: src/fat_cluster_chain_sector_step.sv
// FAT12/16/32 cluster-chain sector stepper, top level.
// A request passes through the input register, the step logic and the result
// register. Throughput: one request per cycle unless the result side stalls.
// Input register doubles as skid stage, so a request is taken while a result waits.
// Reset (synchronous, active low) empties both stages, clears the pending FAT
// request and returns the registers to their reset values. Depends on fccs_pkg.
module fat_cluster_chain_sector_step #(
    parameter int SECTOR_SHIFT = fccs_pkg::SECTOR_SHIFT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fccs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fccs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fccs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fccs_pkg::t_in                   i_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fccs_pkg::t_out                  o_out
);
    import fccs_pkg::*;

    t_cfg cfg;
    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    t_out step_res;
    logic take;
    logic advance;

    fccs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fccs_step #(
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (step_res)
    );

    // Handshake: input stage moves on when the result stage is free or drains
    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && r_out_vld && i_out_stall;
    assign take        = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

endmodule

FILE: src/fccs_checker.sv
// Port-level checks for the FAT cluster-chain sector stepper, bound to the
// top level. Depends on fccs_pkg and fat_cluster_chain_sector_step.
module fccs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input fccs_pkg::t_out                  o_out
);
    import fccs_pkg::*;

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Requests back up only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled while result side is free");

    // A held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Only a FAT request carries a FAT location, only a next sector a sector
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out.outcome == OUT_NEED || (o_out.fat_sector == '0 && o_out.fat_byte == '0))
            && (o_out.outcome == OUT_NEXT || o_out.next_sector == '0))
        else $error("result field set for wrong outcome");

endmodule

bind fat_cluster_chain_sector_step fccs_checker u_fccs_checker (.*);

FILE: bench/tb_fat_cluster_chain_sector_step.sv
// Self-checking bench for the FAT cluster-chain sector stepper.
// Drives step queries and FAT entry deliveries, predicts each result in-bench
// and checks results in order. Depends on fccs_pkg and fat_cluster_chain_sector_step.
module tb_fat_cluster_chain_sector_step;
    timeunit 1ns;
    timeprecision 1ps;

    import fccs_pkg::*;

    localparam int SEC_SHIFT       = SECTOR_SHIFT_DEF;
    localparam int HOLD_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 210;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    localparam logic [KIND_W-1:0]    KIND_RESERVED    = 2'd3;
    localparam logic [SECTOR_W-1:0]  SECTOR_MAX       = 31'h7FFF_FFFF;
    localparam logic [CLUSTER_W-1:0] END_CLUSTER_MAX  = 28'd268435446;
    localparam logic [CLUSTER_W-1:0] ROOT_CLUSTER_MAX = 28'hFFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;

    // Shadow of the volume geometry registers and of the pending FAT request
    t_cfg geom = '{fat_start: '0, rootdir_start: '0, data_start: '0,
                   end_cluster: FIRST_CLUSTER, cluster_shift: '0,
                   fat_kind: KIND_FAT12, root_cluster: '0};
    logic                 fat_wait         = 1'b0;
    logic [CLUSTER_W-1:0] fat_wait_cluster = '0;

    t_in  sector_reqs[$];
    t_out expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    fat_cluster_chain_sector_step DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    // Next-sector prediction for one request; updates the pending FAT request
    function automatic t_out chain_step(input t_in req);
        t_out        res;
        logic [63:0] sec, rel, span_mask, cl, off, fsec;
        logic [31:0] ent;
        logic        eoc;
        res = '0;
        res.outcome = OUT_ERR;
        if (req.req_type == REQ_QUERY) begin
            fat_wait = 1'b0;
            sec = 64'(req.sector);
            // root area and below
            if (sec < 64'(geom.data_start)) begin
                if (sec < 64'(geom.rootdir_start)) begin
                    res.outcome = OUT_ERR;
                end else if (sec + 1 < 64'(geom.data_start)) begin
                    res.outcome = OUT_NEXT;
                    res.next_sector = SECTOR_W'(sec + 1);
                end else begin
                    res.outcome = OUT_END;
                end
                return res;
            end
            rel = sec - 64'(geom.data_start);
            span_mask = (64'd1 << geom.cluster_shift) - 1;
            // inside a cluster
            if ((~rel & span_mask) != 0) begin
                if (sec + 1 <= 64'(SECTOR_MAX)) begin
                    res.outcome = OUT_NEXT;
                    res.next_sector = SECTOR_W'(sec + 1);
                end
                return res;
            end
            // last sector of a cluster: ask for its FAT entry
            cl = 2 + (rel >> geom.cluster_shift);
            if (cl >= 64'(geom.end_cluster))
                return res;
            case (geom.fat_kind)
                KIND_FAT12: off = cl + (cl >> 1);
                KIND_FAT16: off = cl << 1;
                KIND_FAT32: off = cl << 2;
                default:    return res;
            endcase
            fsec = 64'(geom.fat_start) + (off >> SEC_SHIFT);
            if (fsec > 64'(SECTOR_MAX))
                return res;
            fat_wait_cluster = CLUSTER_W'(cl);
            fat_wait = 1'b1;
            res.outcome = OUT_NEED;
            res.fat_sector = SECTOR_W'(fsec);
            res.fat_byte = BYTE_W'(off & ((64'd1 << SEC_SHIFT) - 1));
            return res;
        end
        // FAT entry delivery
        if (!fat_wait)
            return res;
        fat_wait = 1'b0;
        case (geom.fat_kind)
            KIND_FAT12: begin
                ent = {16'd0, req.fat_word[15:0]};
                ent = fat_wait_cluster[0] ? (ent >> 4) : (ent & 32'hFFF);
                eoc = ent >= 32'(EOC_FAT12);
            end
            KIND_FAT16: begin
                ent = {16'd0, req.fat_word[15:0]};
                eoc = ent >= 32'(EOC_FAT16);
            end
            KIND_FAT32: begin
                ent = {4'd0, req.fat_word[27:0]};
                eoc = ent >= 32'(EOC_FAT32);
            end
            default: return res;
        endcase
        if (eoc) begin
            res.outcome = OUT_END;
            return res;
        end
        // cluster 0 stands for the root directory
        if (ent == 0)
            ent = 32'(geom.root_cluster);
        if (ent == 0) begin
            res.outcome = OUT_NEXT;
            res.next_sector = geom.rootdir_start;
        end else if (ent >= 2 && ent < 32'(geom.end_cluster)) begin
            fsec = 64'(geom.data_start) + ((64'(ent) - 2) << geom.cluster_shift);
            if (fsec <= 64'(SECTOR_MAX)) begin
                res.outcome = OUT_NEXT;
                res.next_sector = SECTOR_W'(fsec);
            end
        end
        return res;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                expected_results.push_back(chain_step(i_in));
            if (sector_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in <= sector_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Result monitor and receiver stall
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result", 64'd0, 64'(o_out));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.outcome !== want.outcome)
                        flag_mismatch("outcome", 64'(want.outcome), 64'(o_out.outcome));
                    if (o_out.next_sector !== want.next_sector)
                        flag_mismatch("next_sector", 64'(want.next_sector),
                                      64'(o_out.next_sector));
                    if (o_out.fat_sector !== want.fat_sector)
                        flag_mismatch("fat_sector", 64'(want.fat_sector),
                                      64'(o_out.fat_sector));
                    if (o_out.fat_byte !== want.fat_byte)
                        flag_mismatch("fat_byte", 64'(want.fat_byte), 64'(o_out.fat_byte));
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_requests != hold_taken) begin
                hold_taken = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FAT_START:     geom.fat_start     = val[SECTOR_W-1:0];
            REG_ROOTDIR_START: geom.rootdir_start = val[SECTOR_W-1:0];
            REG_DATA_START:    geom.data_start    = val[SECTOR_W-1:0];
            REG_END_CLUSTER:   geom.end_cluster   = val[CLUSTER_W-1:0];
            REG_CLUSTER_SHIFT: geom.cluster_shift = val[SHIFT_W-1:0];
            REG_FAT_KIND:      geom.fat_kind      = val[KIND_W-1:0];
            REG_ROOT_CLUSTER:  geom.root_cluster  = val[CLUSTER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input t_cfg g);
        reg_write(REG_FAT_START,     32'(g.fat_start));
        reg_write(REG_ROOTDIR_START, 32'(g.rootdir_start));
        reg_write(REG_DATA_START,    32'(g.data_start));
        reg_write(REG_END_CLUSTER,   32'(g.end_cluster));
        reg_write(REG_CLUSTER_SHIFT, 32'(g.cluster_shift));
        reg_write(REG_FAT_KIND,      32'(g.fat_kind));
        reg_write(REG_ROOT_CLUSTER,  32'(g.root_cluster));
    endtask

    task automatic queue_req(input logic kind, input logic [63:0] sec, input logic [31:0] word);
        t_in r;
        r.req_type = kind;
        r.sector = sec[SECTOR_W-1:0];
        r.fat_word = word;
        sector_reqs.push_back(r);
    endtask

    // Wait until every request is answered, then let the pipeline settle
    task automatic drain();
        while (sector_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // FAT bytes that encode target as the entry of cluster owner
    function automatic logic [31:0] entry_word(input logic [CLUSTER_W-1:0] owner,
                                               input logic [31:0] target);
        logic [31:0] w;
        w = $urandom;
        case (geom.fat_kind)
            KIND_FAT12: begin
                if (owner[0])
                    w[15:4] = target[11:0];
                else
                    w[11:0] = target[11:0];
            end
            KIND_FAT16: w[15:0] = target[15:0];
            default:    w[27:0] = target[27:0];
        endcase
        return w;
    endfunction

    function automatic logic [CLUSTER_W-1:0] pick_cluster();
        logic [31:0] span;
        span = 32'(geom.end_cluster) - 2;
        if (geom.end_cluster <= FIRST_CLUSTER)
            return FIRST_CLUSTER;
        case ($urandom_range(0, 9))
            0:       return CLUSTER_W'(geom.end_cluster - 1);
            1:       return geom.end_cluster;
            2:       return FIRST_CLUSTER;
            default: return CLUSTER_W'(2 + $urandom % span);
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        logic [31:0] mark;
        case (geom.fat_kind)
            KIND_FAT12: mark = 32'(EOC_FAT12);
            KIND_FAT16: mark = 32'(EOC_FAT16);
            default:    mark = 32'(EOC_FAT32);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'(pick_cluster());
            4:          return 32'd0;
            5:          return 32'd1;
            6:          return mark + $urandom_range(0, 7);
            7:          return 32'(geom.end_cluster) + $urandom_range(0, 3);
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_cfg random_geometry(input int phase);
        t_cfg g;
        g.fat_start = ($urandom_range(0, 9) == 0) ? SECTOR_W'($urandom)
                                                  : SECTOR_W'($urandom_range(0, 2000));
        if (phase == 0)
            g.fat_start = '0;
        g.rootdir_start = g.fat_start + SECTOR_W'($urandom_range(1, 400));
        g.data_start = g.rootdir_start + SECTOR_W'($urandom_range(0, 40));
        g.end_cluster = ($urandom_range(0, 7) == 0) ? END_CLUSTER_MAX
                                                    : CLUSTER_W'($urandom_range(3, 6000));
        g.cluster_shift = ($urandom_range(0, 9) == 0) ? SHIFT_W'($urandom_range(9, 15))
                                                      : SHIFT_W'($urandom_range(0, 8));
        g.fat_kind = KIND_W'($urandom_range(0, 2));
        case (phase)
            0: begin
                g.cluster_shift = '0;
                g.fat_kind = KIND_FAT12;
            end
            1: begin
                g.cluster_shift = SHIFT_W'(8);
                g.end_cluster = END_CLUSTER_MAX;
                g.fat_kind = KIND_FAT32;
            end
            2: g.fat_kind = KIND_FAT16;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0:       g.root_cluster = '0;
            1:       g.root_cluster = ROOT_CLUSTER_MAX;
            default: g.root_cluster = CLUSTER_W'(2 + $urandom % (32'(g.end_cluster) - 2));
        endcase
        return g;
    endfunction

    // Cluster-end queries, mostly followed by their FAT entry, plus noise
    task automatic queue_random_traffic(input int count);
        int          made;
        int unsigned pick;
        logic [CLUSTER_W-1:0] c;
        logic [63:0] base, sec;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            c = pick_cluster();
            base = 64'(geom.data_start) + ((64'(c) - 2) << geom.cluster_shift);
            if (pick < 45) begin
                queue_req(REQ_QUERY, base + (64'd1 << geom.cluster_shift) - 1, $urandom);
                made++;
                // stray query drops the outstanding request
                if ($urandom_range(0, 9) == 0) begin
                    queue_req(REQ_QUERY, 64'($urandom), $urandom);
                    made++;
                end
                if ($urandom_range(0, 19) != 0) begin
                    queue_req(REQ_ENTRY, 64'($urandom), entry_word(c, pick_target()));
                    made++;
                end
            end else if (pick < 65) begin
                sec = base + $urandom_range(0, (32'd1 << geom.cluster_shift) - 1);
                queue_req(REQ_QUERY, sec, $urandom);
                made++;
            end else if (pick < 75) begin
                case ($urandom_range(0, 2))
                    0:       sec = 64'(geom.rootdir_start) - 1;
                    1:       sec = 64'(geom.data_start) - 1;
                    default: sec = 64'(geom.rootdir_start) + $urandom_range(0, 40);
                endcase
                queue_req(REQ_QUERY, sec, $urandom);
                made++;
            end else if (pick < 85) begin
                queue_req(REQ_ENTRY, 64'($urandom), $urandom);
                made++;
            end else begin
                queue_req(REQ_QUERY, 64'($urandom), $urandom);
                made++;
            end
        end
    endtask

    // Reset, directed cases, random phases, final verdict
    initial begin
        t_cfg geo;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values written back explicitly
        geo = '{fat_start: '0, rootdir_start: '0, data_start: '0,
                end_cluster: FIRST_CLUSTER, cluster_shift: '0,
                fat_kind: KIND_FAT12, root_cluster: '0};
        write_config(geo);
        queue_req(REQ_QUERY, 64'd0, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), $urandom);
        drain();

        // small FAT12 volume: root area, cluster steps, entry decode
        geo = '{fat_start: 31'd1, rootdir_start: 31'd10, data_start: 31'd20,
                end_cluster: 28'd100, cluster_shift: 4'd2,
                fat_kind: KIND_FAT12, root_cluster: '0};
        write_config(geo);
        queue_req(REQ_QUERY, 64'd5, $urandom);
        queue_req(REQ_QUERY, 64'd10, $urandom);
        queue_req(REQ_QUERY, 64'd19, $urandom);
        queue_req(REQ_QUERY, 64'd23, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), entry_word(28'd2, 32'(EOC_FAT12)));
        queue_req(REQ_QUERY, 64'd27, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), entry_word(28'd3, 32'd0));
        queue_req(REQ_QUERY, 64'd27, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), entry_word(28'd3, 32'd1));
        queue_req(REQ_QUERY, 64'd27, $urandom);
        queue_req(REQ_QUERY, 64'd20, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), $urandom);
        queue_req(REQ_QUERY, 64'd415, $urandom);
        drain();

        // sums past 31 bits, large cluster shift, root cluster out of range
        geo = '{fat_start: SECTOR_MAX, rootdir_start: '0, data_start: 31'h7000_0001,
                end_cluster: END_CLUSTER_MAX, cluster_shift: 4'd9,
                fat_kind: KIND_FAT32, root_cluster: ROOT_CLUSTER_MAX};
        write_config(geo);
        queue_req(REQ_QUERY, 64'h7FFF_FFFF, $urandom);
        queue_req(REQ_QUERY, 64'h7FFF_FE00, $urandom);
        queue_req(REQ_QUERY, 64'h7000_0200, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), entry_word(28'd2, 32'h00FF_FFFF));
        queue_req(REQ_QUERY, 64'h7000_0200, $urandom);
        queue_req(REQ_ENTRY, 64'($urandom), entry_word(28'd2, 32'd0));
        queue_req(REQ_QUERY, 64'h7000_0200, $urandom);
        drain();

        // reserved FAT kind, with a request still outstanding
        geo = '{fat_start: '0, rootdir_start: '0, data_start: '0,
                end_cluster: 28'd3, cluster_shift: '0,
                fat_kind: KIND_RESERVED, root_cluster: '0};
        write_config(geo);
        queue_req(REQ_ENTRY, 64'($urandom), $urandom);
        queue_req(REQ_QUERY, 64'd0, $urandom);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_config(random_geometry(p));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            queue_random_traffic(PHASE_ITEMS);
            if (p == 4) begin
                // back-pressure: receiver holds off while requests keep coming
                hold_requests++;
                while (sector_reqs.size() > PHASE_ITEMS / 2)
                    @(posedge i_clk);
                hold_requests++;
            end
            drain();
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
